/* design/rrfmc_pkg.sv */
// rrfmc_pkg: shared types and constants of the range rule classifier
// holds op codes, register indexes, fixed widths and the token handed along the cell chain
// no dependencies
package rrfmc_pkg;

	// fixed field widths
	localparam int unsigned VAL_W      = 16;
	localparam int unsigned COORD_W    = 12;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned MASK_W     = 9;
	localparam int unsigned CLASS_W    = 8;
	localparam int unsigned RULE_IDX_W = 4;
	localparam int unsigned NUM_BOUNDS = 8;
	localparam int unsigned BIDX_W     = 3;
	localparam int unsigned NUM_VALS   = 4;

	// latitude math: 90.0 and 180.0 in Q8.8, dividend row * span
	localparam int unsigned LAT_W    = 17;
	localparam logic [LAT_W-1:0] LAT_TOP  = 17'd23040;
	localparam logic [LAT_W-1:0] LAT_SPAN = 17'd46080;
	localparam int unsigned PROD_W   = 28;
	localparam int unsigned QUOT_W   = 16;

	// divider: quotient bits retired per cycle
	localparam int unsigned DIV_STEPS  = 2;
	localparam int unsigned DIV_CYCLES = QUOT_W / DIV_STEPS;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

	// mask bit that makes a rule match everything
	localparam int unsigned MATCH_ALL_BIT = 8;

	// item op codes
	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_APPEND   = 2'd1,
		OP_BOUND    = 2'd2,
		OP_CLASSIFY = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_MAP_WIDTH  = 1'b0,
		REG_MAP_HEIGHT = 1'b1
	} reg_idx_t;

	// sample token moving down the cell chain
	typedef struct packed {
		logic                             valid;
		logic                             resolved;
		logic                             matched;
		logic [CLASS_W-1:0]               class_code;
		logic [RULE_IDX_W-1:0]            rule_index;
		logic [NUM_VALS-1:0][VAL_W-1:0]   vals;
	} tok_t;

	// rule table write controls broadcast to every cell
	typedef struct packed {
		logic                hdr_wr;
		logic                bnd_wr;
		logic [MASK_W-1:0]   rule_mask;
		logic [CLASS_W-1:0]  rule_class;
		logic [BIDX_W-1:0]   bound_index;
		logic [VAL_W-1:0]    bound_value;
	} rule_wr_t;

endpackage

/* design/range_rule_first_match_classifier.sv */
// range_rule_first_match_classifier: first-match range rule classifier, top level
// sequencer, map registers, latitude divider and a chain of one cell per rule
// depends on rrfmc_pkg, rrfmc_div, rrfmc_cell
//
//   channel   handshake          payload
//   -------   ----------------   ----------------------------------------------
//   item      start & !busy      op rule_mask rule_class bound_index bound_value
//                                column row temperature rainfall altitude
//   result    done (one cycle)   matched class_code rule_index
//   config    cfg_write          cfg_index cfg_data
//
// clear, append and bound items take effect at the accepting edge; busy stays low.
// a classify item strobes its result once the divider has formed the latitude and the
// token has passed the cell chain: the divider retires two latitude bits a cycle, then the token
// walks the cell chain one rule per cycle. busy is high until the edge that ends the
// strobe cycle, so a new item is not taken before the last result has been strobed.
// arst_n clears the sequencer, the rule count, the map registers and the token valids.
// results are strobed for one cycle; the receiver cannot hold them off.
module range_rule_first_match_classifier #(
	parameter int unsigned MAX_RULES = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            op,
	input  logic [rrfmc_pkg::MASK_W-1:0]          rule_mask,
	input  logic [rrfmc_pkg::CLASS_W-1:0]         rule_class,
	input  logic [rrfmc_pkg::BIDX_W-1:0]          bound_index,
	input  logic signed [rrfmc_pkg::VAL_W-1:0]    bound_value,
	input  logic [rrfmc_pkg::COORD_W-1:0]         column,
	input  logic [rrfmc_pkg::COORD_W-1:0]         row,
	input  logic signed [rrfmc_pkg::VAL_W-1:0]    temperature,
	input  logic signed [rrfmc_pkg::VAL_W-1:0]    rainfall,
	input  logic signed [rrfmc_pkg::VAL_W-1:0]    altitude,
	output logic                                  done,
	output logic                                  matched,
	output logic [rrfmc_pkg::CLASS_W-1:0]         class_code,
	output logic [rrfmc_pkg::RULE_IDX_W-1:0]      rule_index,
	input  logic                                  cfg_write,
	input  logic [0:0]                            cfg_index,
	input  logic [rrfmc_pkg::DIM_W-1:0]           cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHAIN
	} state_t;

	state_t                                   state_q;
	logic [CNT_W-1:0]                         count_q;
	logic [rrfmc_pkg::DIM_W-1:0]              map_width_q;
	logic [rrfmc_pkg::DIM_W-1:0]              map_height_q;
	logic [rrfmc_pkg::VAL_W-1:0]              temp_q;
	logic [rrfmc_pkg::VAL_W-1:0]              rain_q;
	logic [rrfmc_pkg::VAL_W-1:0]              alt_q;
	logic                                     outside_q;
	logic                                     flat_q;
	logic                                     accept;
	logic                                     classify;
	logic                                     outside;
	logic                                     div_done;
	logic [rrfmc_pkg::QUOT_W-1:0]             quotient;
	logic [rrfmc_pkg::LAT_W-1:0]              lat_w;
	rrfmc_pkg::op_t                           op_code;
	rrfmc_pkg::rule_wr_t                      wr;
	rrfmc_pkg::tok_t                          tok [MAX_RULES+1];

	assign op_code  = rrfmc_pkg::op_t'(op);
	assign busy     = state_q != ST_IDLE;
	assign accept   = start && !busy;
	assign classify = accept && op_code == rrfmc_pkg::OP_CLASSIFY;

	// map bounds check; a zero dimension puts every sample outside
	assign outside = ({1'b0, column} >= map_width_q) || ({1'b0, row} >= map_height_q);

	// rule table writes broadcast to the cells
	always_comb begin
		wr.hdr_wr      = accept && op_code == rrfmc_pkg::OP_APPEND
		                 && count_q < CNT_W'(MAX_RULES);
		wr.bnd_wr      = accept && op_code == rrfmc_pkg::OP_BOUND && count_q != '0;
		wr.rule_mask   = rule_mask;
		wr.rule_class  = rule_class;
		wr.bound_index = bound_index;
		wr.bound_value = bound_value;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= '0;
			map_height_q <= '0;
		end else if (cfg_write) begin
			unique case (rrfmc_pkg::reg_idx_t'(cfg_index))
				rrfmc_pkg::REG_MAP_WIDTH:  map_width_q  <= cfg_data;
				rrfmc_pkg::REG_MAP_HEIGHT: map_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// rule count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && op_code == rrfmc_pkg::OP_CLEAR) begin
			count_q <= '0;
		end else if (wr.hdr_wr) begin
			count_q <= count_q + 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (classify) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CHAIN;
					end
				end
				ST_CHAIN: begin
					if (tok[MAX_RULES].valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (classify) begin
			temp_q    <= temperature;
			rain_q    <= rainfall;
			alt_q     <= altitude;
			outside_q <= outside;
			flat_q    <= map_height_q <= rrfmc_pkg::DIM_W'(1);
		end
	end

	rrfmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (classify),
		.row      (row),
		.height   (map_height_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// latitude and token injection
	assign lat_w = rrfmc_pkg::LAT_TOP - {1'b0, quotient};

	always_comb begin
		tok[0].valid      = state_q == ST_DIV && div_done;
		tok[0].resolved   = outside_q;
		tok[0].matched    = 1'b0;
		tok[0].class_code = '0;
		tok[0].rule_index = '0;
		tok[0].vals[0]    = temp_q;
		tok[0].vals[1]    = rain_q;
		tok[0].vals[2]    = alt_q;
		tok[0].vals[3]    = flat_q ? '0 : lat_w[rrfmc_pkg::VAL_W-1:0];
	end

	// one cell per rule slot
	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		rrfmc_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.rule_count (count_q),
			.wr         (wr),
			.tok_in     (tok[i]),
			.tok_out    (tok[i+1])
		);
	end

	// result strobe
	assign done       = tok[MAX_RULES].valid;
	assign matched    = tok[MAX_RULES].matched;
	assign class_code = tok[MAX_RULES].class_code;
	assign rule_index = tok[MAX_RULES].rule_index;

endmodule

/* design/rrfmc_div.sv */
// rrfmc_div: iterative latitude divider, floor(row * 46080 / height)
// retires two quotient bits per cycle with a restoring subtract
// depends on rrfmc_pkg
module rrfmc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic [rrfmc_pkg::COORD_W-1:0]       row,
	input  logic [rrfmc_pkg::DIM_W-1:0]         height,
	output logic                                done,
	output logic [rrfmc_pkg::QUOT_W-1:0]        quotient
);

	logic                                  run_q;
	logic                                  done_q;
	logic [rrfmc_pkg::DIV_CNT_W-1:0]       cnt_q;
	logic [rrfmc_pkg::DIM_W-1:0]           rem_q;
	logic [rrfmc_pkg::QUOT_W-1:0]          shf_q;
	logic [rrfmc_pkg::PROD_W-1:0]          prod;
	logic [rrfmc_pkg::DIM_W-1:0]           rem_nxt;
	logic [rrfmc_pkg::QUOT_W-1:0]          shf_nxt;

	// dividend; the top bits of the quotient are known zero since row < height
	assign prod = rrfmc_pkg::PROD_W'(row) * rrfmc_pkg::PROD_W'(rrfmc_pkg::LAT_SPAN);

	// restoring steps, dividend bits shift out as quotient bits shift in
	always_comb begin
		logic [rrfmc_pkg::DIM_W:0] t;
		rem_nxt = rem_q;
		shf_nxt = shf_q;
		for (int k = 0; k < rrfmc_pkg::DIV_STEPS; k++) begin
			t = {rem_nxt, shf_nxt[rrfmc_pkg::QUOT_W-1]};
			shf_nxt = {shf_nxt[rrfmc_pkg::QUOT_W-2:0], 1'b0};
			if (t >= {1'b0, height}) begin
				t = t - {1'b0, height};
				shf_nxt[0] = 1'b1;
			end
			rem_nxt = t[rrfmc_pkg::DIM_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rrfmc_pkg::DIV_CNT_W'(rrfmc_pkg::DIV_CYCLES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {1'b0, prod[rrfmc_pkg::PROD_W-1:rrfmc_pkg::QUOT_W]};
			shf_q <= prod[rrfmc_pkg::QUOT_W-1:0];
		end else if (run_q) begin
			rem_q <= rem_nxt;
			shf_q <= shf_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = shf_q;

endmodule

/* design/rrfmc_cell.sv */
// rrfmc_cell: one rule slot of the classifier chain
// holds mask, class and eight bounds; checks the passing token and hands it on
// depends on rrfmc_pkg
module rrfmc_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CNT_W = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [CNT_W-1:0]        rule_count,
	input  rrfmc_pkg::rule_wr_t     wr,
	input  rrfmc_pkg::tok_t         tok_in,
	output rrfmc_pkg::tok_t         tok_out
);

	localparam logic [CNT_W-1:0] SLOT     = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] SLOT_NXT = CNT_W'(INDEX + 1);
	localparam logic [31:0]      IDX32    = 32'(INDEX);

	logic [rrfmc_pkg::MASK_W-1:0]                            mask_q;
	logic [rrfmc_pkg::CLASS_W-1:0]                           class_q;
	logic [rrfmc_pkg::NUM_BOUNDS-1:0][rrfmc_pkg::VAL_W-1:0]  bound_q;
	rrfmc_pkg::tok_t                                         tok_q;
	logic                                                    active;
	logic                                                    holds;

	assign active = SLOT < rule_count;

	// rule header lands in the slot at the fill count, bounds go to the last rule
	always_ff @(posedge clk) begin
		if (wr.hdr_wr && rule_count == SLOT) begin
			mask_q  <= wr.rule_mask;
			class_q <= wr.rule_class;
		end
		if (wr.bnd_wr && rule_count == SLOT_NXT) begin
			bound_q[wr.bound_index] <= wr.bound_value;
		end
	end

	// even bounds are minimums, odd bounds maximums
	always_comb begin
		holds = 1'b1;
		for (int b = 0; b < rrfmc_pkg::NUM_BOUNDS; b++) begin
			if (mask_q[b]) begin
				if ((b % 2) == 0) begin
					if ($signed(tok_in.vals[b/2]) < $signed(bound_q[b])) begin
						holds = 1'b0;
					end
				end else begin
					if ($signed(tok_in.vals[b/2]) > $signed(bound_q[b])) begin
						holds = 1'b0;
					end
				end
			end
		end
		if (mask_q[rrfmc_pkg::MATCH_ALL_BIT]) begin
			holds = 1'b1;
		end
	end

	// token register, first match wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.vals  <= tok_in.vals;
			if (!tok_in.resolved && active && holds) begin
				tok_q.resolved   <= 1'b1;
				tok_q.matched    <= 1'b1;
				tok_q.class_code <= class_q;
				tok_q.rule_index <= IDX32[rrfmc_pkg::RULE_IDX_W-1:0];
			end else begin
				tok_q.resolved   <= tok_in.resolved;
				tok_q.matched    <= tok_in.matched;
				tok_q.class_code <= tok_in.class_code;
				tok_q.rule_index <= tok_in.rule_index;
			end
		end
	end

	assign tok_out = tok_q;

endmodule
